// File: hw/rtl/scalar_kalman_filter_unit_macros.svh
// Assertion macros for the scalar Kalman filter block.
// Used by scalar_kalman_filter_unit.sv; needs clk and rst_n in scope where used.
`ifndef SCALAR_KALMAN_FILTER_UNIT_MACROS_SVH
`define SCALAR_KALMAN_FILTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SKF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("skf assertion failed");
// next-cycle implication
`define SKF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("skf assertion failed");
`else
`define SKF_ASSERT_IMP(lbl, ante, cons)
`define SKF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/skf_pkg.sv
// Shared types, constants and helpers for the scalar Kalman filter block.
// No dependencies; imported by every module of the block.
package skf_pkg;

  // IEEE single fields
  localparam int FP_FRAC_W = 23;
  localparam logic [7:0]  FP_EXP_ONES = 8'hff;
  localparam logic [30:0] FP_INF_MAG  = 31'h7f800000;
  localparam logic [31:0] FP_QNAN     = 32'h7fc00000;
  localparam logic [31:0] FP_ONE      = 32'h3f800000;

  // register reset values
  localparam logic [31:0] RST_NOISE = 32'h3dcccccd;
  localparam logic [31:0] RST_EST   = 32'h00000000;

  // quotient bits produced by the divider (integer bit, 23 fraction, 3 extra)
  localparam int DIV_STEPS = 27;

  localparam int CFG_ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_PROC_NOISE = 2'd0,
    REG_MEAS_NOISE = 2'd1,
    REG_INIT_EST   = 2'd2,
    REG_INIT_COV   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    FOP_ADD,
    FOP_MUL,
    FOP_DIV
  } fop_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_PREP,
    F_ADD,
    F_DNORM,
    F_DIV,
    F_NORM,
    F_ROUND,
    F_DONE
  } fpu_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PADD,
    S_DEN,
    S_DIV,
    S_DIFF,
    S_MULK,
    S_XADD,
    S_ONEK,
    S_MULP,
    S_FINISH
  } seq_state_t;

  typedef struct packed {
    logic        start;
    fop_t        op;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic        busy;
    logic [31:0] result;
  } fpu_rsp_t;

  typedef struct packed {
    logic [31:0] q;
    logic [31:0] r;
    logic        ld_x;
    logic        ld_p;
    logic [31:0] ld_val;
  } cfg_t;

  // exponent all ones: Inf or NaN
  function automatic logic not_finite(input logic [31:0] b);
    return b[30:FP_FRAC_W] == FP_EXP_ONES;
  endfunction

  function automatic logic [31:0] fp_neg(input logic [31:0] b);
    return {~b[31], b[30:0]};
  endfunction

endpackage

// File: hw/rtl/skf_if.sv
// Valid/ready channel interfaces for the scalar Kalman filter block.
// No dependencies.
interface skf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] measurement;
  logic        last_sample;
  modport source (output valid, measurement, last_sample, input ready);
  modport sink   (input valid, measurement, last_sample, output ready);
endinterface

interface skf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] estimate;
  logic [31:0] gain;
  logic        overflow_error;
  logic        end_of_block;
  modport source (output valid, estimate, gain, overflow_error, end_of_block, input ready);
  modport sink   (input valid, estimate, gain, overflow_error, end_of_block, output ready);
endinterface

// File: hw/rtl/skf_cfg.sv
// APB-style register file: noise terms and initial state values.
// Depends on skf_pkg.
module skf_cfg import skf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [31:0] q_r, r_r, ie_r, ic_r;
  logic [31:0] q_nxt, r_nxt, ie_nxt, ic_nxt;
  logic        wr_en;
  reg_idx_t    idx;

  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;

  // write decode
  always_comb begin
    q_nxt  = q_r;
    r_nxt  = r_r;
    ie_nxt = ie_r;
    ic_nxt = ic_r;
    if (wr_en) begin
      unique case (idx)
        REG_PROC_NOISE: q_nxt  = pwdata;
        REG_MEAS_NOISE: r_nxt  = pwdata;
        REG_INIT_EST:   ie_nxt = pwdata;
        REG_INIT_COV:   ic_nxt = pwdata;
        default:        q_nxt  = q_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r  <= RST_NOISE;
      r_r  <= RST_NOISE;
      ie_r <= RST_EST;
      ic_r <= RST_NOISE;
    end else begin
      q_r  <= q_nxt;
      r_r  <= r_nxt;
      ie_r <= ie_nxt;
      ic_r <= ic_nxt;
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_PROC_NOISE: prdata = q_r;
      REG_MEAS_NOISE: prdata = r_r;
      REG_INIT_EST:   prdata = ie_r;
      REG_INIT_COV:   prdata = ic_r;
      default:        prdata = q_r;
    endcase
  end

  // noise outputs and state reload strobes
  assign cfg.q      = q_r;
  assign cfg.r      = r_r;
  assign cfg.ld_x   = wr_en && (idx == REG_INIT_EST);
  assign cfg.ld_p   = wr_en && (idx == REG_INIT_COV);
  assign cfg.ld_val = pwdata;

endmodule

// File: hw/rtl/skf_fpu.sv
// Shared multi-cycle IEEE single unit: add, multiply, radix-2 divide,
// stepwise normalize and round-to-nearest-even. Depends on skf_pkg.
module skf_fpu import skf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  fpu_req_t req,
  output fpu_rsp_t rsp
);

  fpu_state_t fst_r, fst_nxt;

  logic [31:0]        a_r, b_r, a_nxt, b_nxt;
  fop_t               op_r, op_nxt;
  logic               sgn_r, sgn_nxt;
  logic signed [11:0] e_r, e_nxt;
  logic [49:0]        w_r, w_nxt;
  // add: big/small mantissa; divide: dividend/divisor
  logic [23:0]        mb_r, ms_r, mb_nxt, ms_nxt;
  logic [7:0]         eb_r, d_r, eb_nxt, d_nxt;
  logic               sub_r, sub_nxt;
  logic [24:0]        rem_r, rem_nxt;
  logic [26:0]        q_r, q_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic [31:0]        res_r, res_nxt;

  // operand unpack
  logic [7:0]  exa, exb;
  logic [23:0] ma, mb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sx;
  logic        spec_hit;
  logic [31:0] spec_val;

  assign exa    = (a_r[30:23] == 8'd0) ? 8'd1 : a_r[30:23];
  assign exb    = (b_r[30:23] == 8'd0) ? 8'd1 : b_r[30:23];
  assign ma     = {|a_r[30:23], a_r[22:0]};
  assign mb     = {|b_r[30:23], b_r[22:0]};
  assign a_nan  = (a_r[30:23] == FP_EXP_ONES) && (a_r[22:0] != 23'd0);
  assign b_nan  = (b_r[30:23] == FP_EXP_ONES) && (b_r[22:0] != 23'd0);
  assign a_inf  = a_r[30:0] == FP_INF_MAG;
  assign b_inf  = b_r[30:0] == FP_INF_MAG;
  assign a_zero = a_r[30:0] == 31'd0;
  assign b_zero = b_r[30:0] == 31'd0;
  assign sx     = a_r[31] ^ b_r[31];

  // special operands
  always_comb begin
    spec_hit = 1'b1;
    spec_val = FP_QNAN;
    case (op_r)
      FOP_ADD: begin
        if (a_nan || b_nan)                           spec_val = FP_QNAN;
        else if (a_inf && b_inf && (a_r[31] != b_r[31])) spec_val = FP_QNAN;
        else if (a_inf)                               spec_val = a_r;
        else if (b_inf)                               spec_val = b_r;
        else if (a_zero && b_zero)                    spec_val = {a_r[31] & b_r[31], 31'd0};
        else if (a_zero)                              spec_val = b_r;
        else if (b_zero)                              spec_val = a_r;
        else                                          spec_hit = 1'b0;
      end
      FOP_MUL: begin
        if (a_nan || b_nan)                           spec_val = FP_QNAN;
        else if ((a_inf && b_zero) || (a_zero && b_inf)) spec_val = FP_QNAN;
        else if (a_inf || b_inf)                      spec_val = {sx, FP_INF_MAG};
        else if (a_zero || b_zero)                    spec_val = {sx, 31'd0};
        else                                          spec_hit = 1'b0;
      end
      default: begin
        if (a_nan || b_nan)                           spec_val = FP_QNAN;
        else if ((a_inf && b_inf) || (a_zero && b_zero)) spec_val = FP_QNAN;
        else if (a_inf || b_zero)                     spec_val = {sx, FP_INF_MAG};
        else if (a_zero || b_inf)                     spec_val = {sx, 31'd0};
        else                                          spec_hit = 1'b0;
      end
    endcase
  end

  // align and add
  logic [26:0] s27, al27, mask27;
  logic        al_st;
  logic [27:0] big28, sm28, sum28;

  always_comb begin
    s27    = {ms_r, 3'd0};
    mask27 = '0;
    if (d_r >= 8'd27) begin
      al27  = '0;
      al_st = |ms_r;
    end else begin
      al27   = s27 >> d_r[4:0];
      mask27 = (27'd1 << d_r[4:0]) - 27'd1;
      al_st  = |(s27 & mask27);
    end
    big28 = {1'b0, mb_r, 3'd0};
    sm28  = {1'b0, al27[26:1], al27[0] | al_st};
    sum28 = sub_r ? (big28 - sm28) : (big28 + sm28);
  end

  // multiply
  logic [47:0] prod48;
  assign prod48 = ma * mb;

  // divide step
  logic        dv_ge;
  logic [24:0] dv_rem;
  logic [26:0] dv_q;
  assign dv_ge  = rem_r >= {1'b0, ms_r};
  assign dv_rem = dv_ge ? (rem_r - {1'b0, ms_r}) : rem_r;
  assign dv_q   = {q_r[25:0], dv_ge};

  // normalize conditions
  logic nm_right, nm_right8, nm_left, nm_left8, nm_done;
  assign nm_right  = e_r < 12'sd1;
  assign nm_right8 = e_r < -12'sd7;
  assign nm_left   = !w_r[49] && (e_r > 12'sd1);
  assign nm_left8  = (w_r[49:42] == 8'd0) && (e_r > 12'sd8);
  assign nm_done   = !nm_right && !nm_left;

  // round and pack
  logic [7:0]  rd_ef;
  logic [30:0] rd_base, rd_val;
  logic        rd_inc, rd_ovf;
  assign rd_ef   = w_r[49] ? e_r[7:0] : 8'd0;
  assign rd_base = {rd_ef, w_r[48:26]};
  assign rd_inc  = w_r[25] & ((|w_r[24:0]) | w_r[26]);
  assign rd_val  = rd_base + {30'd0, rd_inc};
  assign rd_ovf  = e_r >= 12'sd255;

  logic signed [11:0] ea_s, eb_s;
  assign ea_s = signed'({4'd0, exa});
  assign eb_s = signed'({4'd0, exb});

  // next state
  always_comb begin
    fst_nxt = fst_r;
    unique case (fst_r)
      F_IDLE:  if (req.start) fst_nxt = F_PREP;
      F_PREP: begin
        if (spec_hit)            fst_nxt = F_DONE;
        else if (op_r == FOP_ADD) fst_nxt = F_ADD;
        else if (op_r == FOP_MUL) fst_nxt = F_NORM;
        else                     fst_nxt = F_DNORM;
      end
      F_ADD:   fst_nxt = (sum28 == 28'd0) ? F_DONE : F_NORM;
      F_DNORM: if (mb_r[23] && ms_r[23]) fst_nxt = F_DIV;
      F_DIV:   if (cnt_r == 5'(DIV_STEPS - 1)) fst_nxt = F_NORM;
      F_NORM:  if (nm_done) fst_nxt = F_ROUND;
      F_ROUND: fst_nxt = F_DONE;
      F_DONE:  fst_nxt = F_IDLE;
      default: fst_nxt = F_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    op_nxt  = op_r;
    sgn_nxt = sgn_r;
    e_nxt   = e_r;
    w_nxt   = w_r;
    mb_nxt  = mb_r;
    ms_nxt  = ms_r;
    eb_nxt  = eb_r;
    d_nxt   = d_r;
    sub_nxt = sub_r;
    rem_nxt = rem_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    res_nxt = res_r;
    case (fst_r)
      F_IDLE: begin
        if (req.start) begin
          a_nxt  = req.a;
          b_nxt  = req.b;
          op_nxt = req.op;
        end
      end
      F_PREP: begin
        res_nxt = spec_val;
        sub_nxt = sx;
        case (op_r)
          FOP_ADD: begin
            if (a_r[30:0] < b_r[30:0]) begin
              sgn_nxt = b_r[31];
              mb_nxt  = mb;
              ms_nxt  = ma;
              eb_nxt  = exb;
              d_nxt   = exb - exa;
            end else begin
              sgn_nxt = a_r[31];
              mb_nxt  = ma;
              ms_nxt  = mb;
              eb_nxt  = exa;
              d_nxt   = exa - exb;
            end
          end
          FOP_MUL: begin
            sgn_nxt = sx;
            w_nxt   = {prod48, 2'd0};
            e_nxt   = ea_s + eb_s - 12'sd126;
          end
          default: begin
            sgn_nxt = sx;
            mb_nxt  = ma;
            ms_nxt  = mb;
            e_nxt   = ea_s - eb_s + 12'sd127;
          end
        endcase
      end
      F_ADD: begin
        res_nxt = 32'd0;
        w_nxt   = {sum28, 22'd0};
        e_nxt   = signed'({4'd0, eb_r}) + 12'sd1;
      end
      F_DNORM: begin
        // bring both mantissas to a set hidden bit
        if (!mb_r[23]) mb_nxt = {mb_r[22:0], 1'b0};
        if (!ms_r[23]) ms_nxt = {ms_r[22:0], 1'b0};
        e_nxt   = e_r - {11'd0, !mb_r[23]} + {11'd0, !ms_r[23]};
        rem_nxt = {1'b0, mb_r};
        q_nxt   = '0;
        cnt_nxt = '0;
      end
      F_DIV: begin
        q_nxt   = dv_q;
        rem_nxt = {dv_rem[23:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        w_nxt   = {dv_q, |dv_rem, 22'd0};
      end
      F_NORM: begin
        if (nm_right8) begin
          w_nxt = {8'd0, w_r[49:9], |w_r[8:0]};
          e_nxt = e_r + 12'sd8;
        end else if (nm_right) begin
          w_nxt = {1'b0, w_r[49:2], |w_r[1:0]};
          e_nxt = e_r + 12'sd1;
        end else if (nm_left && nm_left8) begin
          w_nxt = {w_r[41:0], 8'd0};
          e_nxt = e_r - 12'sd8;
        end else if (nm_left) begin
          w_nxt = {w_r[48:0], 1'b0};
          e_nxt = e_r - 12'sd1;
        end
      end
      F_ROUND: res_nxt = rd_ovf ? {sgn_r, FP_INF_MAG} : {sgn_r, rd_val};
      default: res_nxt = res_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r <= F_IDLE;
    end else begin
      fst_r <= fst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    op_r  <= op_nxt;
    sgn_r <= sgn_nxt;
    e_r   <= e_nxt;
    w_r   <= w_nxt;
    mb_r  <= mb_nxt;
    ms_r  <= ms_nxt;
    eb_r  <= eb_nxt;
    d_r   <= d_nxt;
    sub_r <= sub_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done   = fst_r == F_DONE;
  assign rsp.busy   = fst_r != F_IDLE;
  assign rsp.result = res_r;

endmodule

// File: hw/rtl/scalar_kalman_filter_unit.sv
// Scalar Kalman filter: one IEEE single measurement per request, one result each.
// Each request runs five add passes, two multiply passes and one 27-step radix-2
// divide on the shared unit; a new request is accepted only once the previous one
// has finished and its result is loaded for output; subnormals or cancellation add steps.
// Synchronous active-low reset loads the register reset values and the state.
// Depends on skf_pkg, skf_if, skf_cfg, skf_fpu and the assertion macro header.
`include "scalar_kalman_filter_unit_macros.svh"
module scalar_kalman_filter_unit import skf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  skf_in_if.sink                in_chan,
  skf_out_if.source             out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t     cfg;
  fpu_req_t fpu_req;
  fpu_rsp_t fpu_rsp;

  skf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  skf_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fpu_req),
    .rsp   (fpu_rsp)
  );

  seq_state_t  seq_r, seq_nxt;
  logic        issued_r, issued_nxt;
  logic [31:0] x_r, p_r, k_r, t_r, m_r;
  logic [31:0] x_nxt, p_nxt, k_nxt, t_nxt, m_nxt;
  logic        last_r, err_r, last_nxt, err_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_est_r, out_gain_r, out_est_nxt, out_gain_nxt;
  logic        out_err_r, out_eob_r, out_err_nxt, out_eob_nxt;

  logic        in_acc, res_bad;
  logic [31:0] res;

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign res     = fpu_rsp.result;
  assign res_bad = not_finite(res);

  // next state
  always_comb begin
    seq_nxt = seq_r;
    unique case (seq_r)
      S_IDLE: if (in_acc) seq_nxt = S_PADD;
      S_PADD: if (fpu_rsp.done) seq_nxt = res_bad ? S_FINISH : S_DEN;
      S_DEN:  if (fpu_rsp.done) seq_nxt = (res[30:0] == 31'd0) ? S_FINISH : S_DIV;
      S_DIV:  if (fpu_rsp.done) seq_nxt = res_bad ? S_FINISH : S_DIFF;
      S_DIFF: if (fpu_rsp.done) seq_nxt = S_MULK;
      S_MULK: if (fpu_rsp.done) seq_nxt = S_XADD;
      S_XADD: if (fpu_rsp.done) seq_nxt = res_bad ? S_FINISH : S_ONEK;
      S_ONEK: if (fpu_rsp.done) seq_nxt = S_MULP;
      S_MULP: if (fpu_rsp.done) seq_nxt = S_FINISH;
      S_FINISH: if (!out_valid_r) seq_nxt = S_IDLE;
      default: seq_nxt = S_IDLE;
    endcase
  end

  // operation issue
  always_comb begin
    fpu_req.start = (seq_r != S_IDLE) && (seq_r != S_FINISH) && !issued_r;
    fpu_req.op    = FOP_ADD;
    fpu_req.a     = p_r;
    fpu_req.b     = cfg.q;
    unique case (seq_r)
      S_DEN:  fpu_req.b = cfg.r;
      S_DIV: begin
        fpu_req.op = FOP_DIV;
        fpu_req.b  = t_r;
      end
      S_DIFF: begin
        fpu_req.a = m_r;
        fpu_req.b = fp_neg(x_r);
      end
      S_MULK: begin
        fpu_req.op = FOP_MUL;
        fpu_req.a  = k_r;
        fpu_req.b  = t_r;
      end
      S_XADD: begin
        fpu_req.a = x_r;
        fpu_req.b = t_r;
      end
      S_ONEK: begin
        fpu_req.a = FP_ONE;
        fpu_req.b = fp_neg(k_r);
      end
      S_MULP: begin
        fpu_req.op = FOP_MUL;
        fpu_req.a  = t_r;
        fpu_req.b  = p_r;
      end
      default: fpu_req.a = p_r;
    endcase
  end

  // state and result capture
  always_comb begin
    issued_nxt    = issued_r;
    x_nxt         = x_r;
    p_nxt         = p_r;
    k_nxt         = k_r;
    t_nxt         = t_r;
    m_nxt         = m_r;
    last_nxt      = last_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    out_est_nxt   = out_est_r;
    out_gain_nxt  = out_gain_r;
    out_err_nxt   = out_err_r;
    out_eob_nxt   = out_eob_r;

    if (fpu_req.start) issued_nxt = 1'b1;
    if (fpu_rsp.done)  issued_nxt = 1'b0;

    if (out_valid_r && out_chan.ready) out_valid_nxt = 1'b0;

    if (cfg.ld_x) x_nxt = cfg.ld_val;
    if (cfg.ld_p) p_nxt = cfg.ld_val;

    unique case (seq_r)
      S_IDLE: begin
        if (in_acc) begin
          m_nxt    = in_chan.measurement;
          last_nxt = in_chan.last_sample;
          err_nxt  = 1'b0;
        end
      end
      S_PADD: if (fpu_rsp.done) begin
        p_nxt   = res;
        err_nxt = res_bad;
      end
      S_DEN: if (fpu_rsp.done) begin
        t_nxt   = res;
        err_nxt = res[30:0] == 31'd0;
      end
      S_DIV: if (fpu_rsp.done) begin
        k_nxt   = res;
        err_nxt = res_bad;
      end
      S_DIFF, S_MULK, S_ONEK: if (fpu_rsp.done) t_nxt = res;
      S_XADD: if (fpu_rsp.done) begin
        x_nxt   = res;
        err_nxt = res_bad;
      end
      S_MULP: if (fpu_rsp.done) begin
        p_nxt   = res;
        err_nxt = res_bad;
      end
      S_FINISH: if (!out_valid_r) begin
        out_valid_nxt = 1'b1;
        out_est_nxt   = err_r ? 32'd0 : x_r;
        out_gain_nxt  = err_r ? 32'd0 : k_r;
        out_err_nxt   = err_r;
        out_eob_nxt   = last_r;
      end
      default: issued_nxt = issued_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= S_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      x_r         <= RST_EST;
      p_r         <= RST_NOISE;
    end else begin
      seq_r       <= seq_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
      x_r         <= x_nxt;
      p_r         <= p_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    t_r        <= t_nxt;
    m_r        <= m_nxt;
    last_r     <= last_nxt;
    err_r      <= err_nxt;
    out_est_r  <= out_est_nxt;
    out_gain_r <= out_gain_nxt;
    out_err_r  <= out_err_nxt;
    out_eob_r  <= out_eob_nxt;
  end

  assign in_chan.ready           = seq_r == S_IDLE;
  assign out_chan.valid          = out_valid_r;
  assign out_chan.estimate       = out_est_r;
  assign out_chan.gain           = out_gain_r;
  assign out_chan.overflow_error = out_err_r;
  assign out_chan.end_of_block   = out_eob_r;

  // checks
  `SKF_ASSERT_NXT(a_busy_after_accept, in_acc, seq_r != S_IDLE)
  `SKF_ASSERT_IMP(a_start_fpu_idle, fpu_req.start, !fpu_rsp.busy)
  `SKF_ASSERT_IMP(a_err_zero, out_valid_r && out_err_r, (out_est_r == 32'd0) && (out_gain_r == 32'd0))
  `SKF_ASSERT_NXT(a_finish_loads, (seq_r == S_FINISH) && !out_valid_r, out_valid_r && (seq_r == S_IDLE))

endmodule
